@@ src/nqnv_pkg.sv @@
// Shared constants and helper functions for the NQN validator.
`default_nettype none

package nqnv_pkg;

    localparam int CH_W       = 8;
    localparam int OUT_W      = 8;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 7;
    localparam int TAG_W      = 3;
    localparam int TAIL_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 10'd224;
    localparam logic [YEAR_W-1:0]  EARLIEST_YEAR = 14'd2010;
    localparam logic [MONTH_W-1:0] FIRST_MONTH   = 7'd1;
    localparam logic [MONTH_W-1:0] LAST_MONTH    = 7'd12;
    localparam logic [TAIL_W-1:0]  UUID_LEN      = 6'd36;
    localparam logic [TAG_W-1:0]   TAG_LEN       = 3'd6;

    localparam logic [LIMIT_W:0]   MIN_NAME_LEN = 11'd12;

    localparam logic [LIMIT_W-1:0] POS_YEAR_END  = 10'd7;
    localparam logic [LIMIT_W-1:0] POS_DASH      = 10'd8;
    localparam logic [LIMIT_W-1:0] POS_MONTH_END = 10'd10;
    localparam logic [LIMIT_W-1:0] POS_DOT       = 10'd11;

    localparam logic [TAIL_W-1:0] SEP_0 = 6'd8;
    localparam logic [TAIL_W-1:0] SEP_1 = 6'd13;
    localparam logic [TAIL_W-1:0] SEP_2 = 6'd18;
    localparam logic [TAIL_W-1:0] SEP_3 = 6'd23;

    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

    function automatic logic [CH_W-1:0] prefix_char(input logic [1:0] i);
        logic [CH_W-1:0] c;
        case (i)
            2'd0:    c = 8'h6E;
            2'd1:    c = 8'h71;
            2'd2:    c = 8'h6E;
            default: c = CH_DOT;
        endcase
        return c;
    endfunction

    function automatic logic [CH_W-1:0] tag_char(input logic [TAG_W-1:0] i);
        logic [CH_W-1:0] c;
        case (i)
            3'd0:    c = CH_COLON;
            3'd1:    c = 8'h75;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h64;
            3'd5:    c = CH_COLON;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/nvme_nqn_validator_unit.sv @@
// Streaming NVMe qualified name validator, one character per transaction.
// The verdict is registered and shows in the cycle after the last character.
// Throughput: one character per cycle; the per-character checks and state update
// sit between the input handshake and the name state and result registers.
// Input stalls only while a verdict is held and the output is not ready.
// Reset clears name state and output valid; allow_empty = 0, length_limit = 224.
`default_nettype none

module nvme_nqn_validator_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [nqnv_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [nqnv_pkg::LIMIT_W-1:0]       cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [nqnv_pkg::CH_W-1:0]          s_axis_tdata,  // [7:0] ch
    input  wire logic                               s_axis_tlast,  // last
    input  wire logic                               s_axis_tuser,  // [0] empty_name
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [nqnv_pkg::OUT_W-1:0]              m_axis_tdata   // [0] valid_res
);

    import nqnv_pkg::*;

    logic                 allow_empty_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic [LIMIT_W-1:0]   pos_reg,   pos_next;
    logic [YEAR_W-1:0]    year_reg,  year_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic                 failed_reg, failed_next;
    logic [TAG_W-1:0]     tag_reg,   tag_next;
    logic                 seen_reg,  seen_next;
    logic [TAIL_W-1:0]    tail_reg,  tail_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 res_reg,   res_next;

    logic                 accept;
    logic [LIMIT_W:0]     n;
    logic [LIMIT_W:0]     limit_ext;
    logic                 is_digit, is_hex, is_allowed;
    logic [3:0]           digit;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, res_reg};

    assign n         = {1'b0, pos_reg} + {{LIMIT_W{1'b0}}, 1'b1};
    assign limit_ext = {1'b0, limit_reg};
    assign digit     = s_axis_tdata[3:0];

    assign is_digit   = (s_axis_tdata >= CH_0) && (s_axis_tdata <= CH_9);
    assign is_hex     = is_digit
                        || ((s_axis_tdata >= CH_LA) && (s_axis_tdata <= CH_LF))
                        || ((s_axis_tdata >= CH_UA) && (s_axis_tdata <= CH_UF));
    assign is_allowed = is_digit
                        || ((s_axis_tdata >= CH_LA) && (s_axis_tdata <= CH_LZ))
                        || ((s_axis_tdata >= CH_UA) && (s_axis_tdata <= CH_UZ))
                        || (s_axis_tdata == CH_DOT) || (s_axis_tdata == CH_DASH)
                        || (s_axis_tdata == CH_COLON);

    // per-character checks, verdict and end-of-name state clear
    always_comb
    begin
        logic [YEAR_W-1:0]  year_calc;
        logic [MONTH_W-1:0] month_calc;
        logic [TAG_W-1:0]   tag_calc;
        logic               ok;

        year_calc   = YEAR_W'((year_reg << 3) + (year_reg << 1) + YEAR_W'(digit));
        month_calc  = MONTH_W'((month_reg << 3) + (month_reg << 1)
                               + MONTH_W'(digit));
        tag_calc    = '0;
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        failed_next = failed_reg;
        tag_next    = tag_reg;
        seen_next   = seen_reg;
        tail_next   = tail_reg;

        if (!failed_reg)
        begin
            if (n >= limit_ext)
            begin
                failed_next = 1'b1;
            end
            if (pos_reg < 10'd4)
            begin
                if (s_axis_tdata != prefix_char(pos_reg[1:0]))
                begin
                    failed_next = 1'b1;
                end
            end
            else if (pos_reg <= POS_YEAR_END)
            begin
                if (!is_digit)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    year_next = year_calc;
                    if ((pos_reg == POS_YEAR_END) && (year_calc < EARLIEST_YEAR))
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
            else if (pos_reg == POS_DASH)
            begin
                if (s_axis_tdata != CH_DASH)
                begin
                    failed_next = 1'b1;
                end
            end
            else if (pos_reg <= POS_MONTH_END)
            begin
                if (!is_digit)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    month_next = month_calc;
                    if ((pos_reg == POS_MONTH_END)
                        && ((month_calc < FIRST_MONTH) || (month_calc > LAST_MONTH)))
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
            else if (pos_reg == POS_DOT)
            begin
                if (s_axis_tdata != CH_DOT)
                begin
                    failed_next = 1'b1;
                end
            end
            else if (!is_allowed)
            begin
                failed_next = 1'b1;
            end
            else if (seen_reg)
            begin
                if (tail_reg >= UUID_LEN)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    if ((tail_reg == SEP_0) || (tail_reg == SEP_1)
                        || (tail_reg == SEP_2) || (tail_reg == SEP_3))
                    begin
                        if (s_axis_tdata != CH_DASH)
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (!is_hex)
                    begin
                        failed_next = 1'b1;
                    end
                    tail_next = tail_reg + 6'd1;
                end
            end
            else
            begin
                if (s_axis_tdata == tag_char(tag_reg))
                begin
                    tag_calc = tag_reg + 3'd1;
                end
                else
                begin
                    tag_calc = (s_axis_tdata == CH_COLON) ? 3'd1 : 3'd0;
                end
                if (tag_calc >= TAG_LEN)
                begin
                    seen_next = 1'b1;
                    tag_next  = '0;
                end
                else
                begin
                    tag_next = tag_calc;
                end
            end
        end

        pos_next = (n < limit_ext) ? n[LIMIT_W-1:0] : limit_reg;

        ok = !failed_next && (n >= MIN_NAME_LEN) && (!seen_next || (tail_next == UUID_LEN));

        out_valid_next = out_valid_reg && !m_axis_tready;
        res_next       = res_reg;

        if (accept)
        begin
            if (s_axis_tuser)
            begin
                out_valid_next = 1'b1;
                res_next       = allow_empty_reg;
            end
            else if (s_axis_tlast)
            begin
                out_valid_next = 1'b1;
                res_next       = ok;
            end
            if (s_axis_tuser || s_axis_tlast)
            begin
                pos_next    = '0;
                year_next   = '0;
                month_next  = '0;
                failed_next = 1'b0;
                tag_next    = '0;
                seen_next   = 1'b0;
                tail_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_empty_reg <= 1'b0;
            limit_reg       <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ALLOW_EMPTY:  allow_empty_reg <= cfg_wdata[0];
                REG_LENGTH_LIMIT: limit_reg       <= cfg_wdata;
                default:          limit_reg       <= limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            failed_reg <= 1'b0;
            tag_reg    <= '0;
            seen_reg   <= 1'b0;
            tail_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            failed_reg <= failed_next;
            tag_reg    <= tag_next;
            seen_reg   <= seen_next;
            tail_reg   <= tail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/nvme_nqn_validator_unit_tb.sv @@
// Self-checking testbench for the streaming NQN validator: directed name table, then random names.
`timescale 1ns / 100ps

module nvme_nqn_validator_unit_tb;

    import nqnv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          RAND_ITEMS  = 200;
    localparam logic [31:0] NQN_HEAD    = "nqn.";
    localparam logic [47:0] UUID_MARK   = ":uuid:";

    typedef struct {
        string text;
        int    pad;
        int    poke_at;
        int    poke_val;
        bit    fin;
        bit    empt;
        int    set_empty;
        int    set_limit;
        int    verdict;
    } name_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CH_W-1:0]      s_axis_tdata = '0;   // [7:0] ch
    logic                 s_axis_tlast = 1'b0; // last
    logic                 s_axis_tuser = 1'b0; // [0] empty_name
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // [0] valid_res

    logic                 allow_empty_r = 1'b0;
    logic [LIMIT_W-1:0]   limit_r = LIMIT_RESET;
    logic [LIMIT_W-1:0]   pos_r;
    logic [YEAR_W-1:0]    year_r;
    logic [MONTH_W-1:0]   month_r;
    logic                 fail_r;
    logic [TAG_W-1:0]     tag_prog_r;
    logic                 tag_hit_r;
    logic [TAIL_W-1:0]    tail_r;

    logic                 verdict_q [$];
    logic [CH_W-1:0]      name_buf [$];
    logic                 want_v;
    bit                   calm = 1'b0;
    int                   faults = 0;
    int                   items_sent = 0;
    int unsigned          cycles = 0;

    string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.:-::";
    string hex_chars  = "0123456789abcdefABCDEF";

    name_row_t dir_rows [30] = '{
        '{"", 0, -1, 0, 1'b1, 1'b1, -1, -1, 0},
        '{"nqn.2014-08.org.example:uuid:f81d4fae-7dec-11d0-a765-00a0c91e6bf6",
          0, -1, 0, 1'b1, 1'b0, -1, -1, 1},
        '{"nqn.2010-01.a", 0, -1, 0, 1'b1, 1'b0, -1, -1, 1},
        '{"nqn.2009-12.a", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.9999-12.Z", 0, -1, 0, 1'b1, 1'b0, -1, -1, 1},
        '{"nqn.2014-13.x", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-00.x", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.", 0, -1, 0, 1'b1, 1'b0, -1, -1, 1},
        '{"nqn.2014-08", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqq.2014-08.abc", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.a_b", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.abc", 0, 13, 255, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.abc", 0, 12, 128, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.x:uuid:1234", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.x:uuid:f81d4fae-7dec-11d0-a765-00a0c91e6bf6a",
          0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.::uuid:F81D4FAE-7DEC-11D0-A765-00A0C91E6BF6",
          0, -1, 0, 1'b1, 1'b0, -1, -1, -1},
        '{"nqn.2014-08.:uuid:f81d4faex7dec-11d0-a765-00a0c91e6bf6",
          0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"n", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.abcd", 0, -1, 0, 1'b0, 1'b0, -1, -1, -1},
        '{"", 0, -1, 0, 1'b1, 1'b1, 1, -1, 1},
        '{"nqn.2014-08.abcdef", 0, -1, 0, 1'b0, 1'b0, -1, -1, -1},
        '{"ghij", 0, -1, 0, 1'b1, 1'b0, -1, 20, -1},
        '{"nqn.2014-08.", 0, -1, 0, 1'b1, 1'b0, -1, 13, 1},
        '{"nqn.2014-08.a", 0, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"nqn.2014-08.", 30, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"n", 0, -1, 0, 1'b1, 1'b0, -1, 1, 0},
        '{"", 0, -1, 0, 1'b1, 1'b1, -1, -1, 1},
        '{"nqn.2014-08.", 47, -1, 0, 1'b1, 1'b0, 0, 60, 1},
        '{"nqn.2014-08.", 48, -1, 0, 1'b1, 1'b0, -1, -1, 0},
        '{"", 0, -1, 0, 1'b1, 1'b1, -1, -1, 0}
    };

    nvme_nqn_validator_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit is_digit(input logic [CH_W-1:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_hex(input logic [CH_W-1:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic bit is_allowed(input logic [CH_W-1:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
               c == CH_DOT || c == CH_DASH || c == CH_COLON;
    endfunction

    task automatic clear_name();
        pos_r      = '0;
        year_r     = '0;
        month_r    = '0;
        fail_r     = 1'b0;
        tag_prog_r = '0;
        tag_hit_r  = 1'b0;
        tail_r     = '0;
    endtask

    task automatic scan_char(input logic [LIMIT_W-1:0] idx, input logic [CH_W-1:0] c);
        if (idx < 4)
        begin
            if (c != NQN_HEAD[8*(3-idx) +: 8])
                fail_r = 1'b1;
        end
        else if (idx < 8)
        begin
            if (!is_digit(c))
                fail_r = 1'b1;
            else
            begin
                year_r = YEAR_W'(year_r * 10 + (c - CH_0));
                if (idx == POS_YEAR_END && year_r < EARLIEST_YEAR)
                    fail_r = 1'b1;
            end
        end
        else if (idx == POS_DASH)
        begin
            if (c != CH_DASH)
                fail_r = 1'b1;
        end
        else if (idx <= POS_MONTH_END)
        begin
            if (!is_digit(c))
                fail_r = 1'b1;
            else
            begin
                month_r = MONTH_W'(month_r * 10 + (c - CH_0));
                if (idx == POS_MONTH_END && (month_r < FIRST_MONTH || month_r > LAST_MONTH))
                    fail_r = 1'b1;
            end
        end
        else if (idx == POS_DOT)
        begin
            if (c != CH_DOT)
                fail_r = 1'b1;
        end
        else if (!is_allowed(c))
            fail_r = 1'b1;
        else if (tag_hit_r)
        begin
            if (tail_r >= UUID_LEN)
                fail_r = 1'b1;
            else
            begin
                if (tail_r == SEP_0 || tail_r == SEP_1 || tail_r == SEP_2 || tail_r == SEP_3)
                begin
                    if (c != CH_DASH)
                        fail_r = 1'b1;
                end
                else if (!is_hex(c))
                    fail_r = 1'b1;
                tail_r = tail_r + 1'b1;
            end
        end
        else
        begin
            if (tag_prog_r < TAG_LEN && c == UUID_MARK[8*(5-tag_prog_r) +: 8])
                tag_prog_r = tag_prog_r + 1'b1;
            else
                tag_prog_r = (c == CH_COLON) ? 3'd1 : 3'd0;
            if (tag_prog_r >= TAG_LEN)
            begin
                tag_hit_r  = 1'b1;
                tag_prog_r = '0;
            end
        end
    endtask

    task automatic advance_name(input logic [CH_W-1:0] c, input logic fin, input logic empt,
                                output logic has, output logic v);
        logic [LIMIT_W:0] n;
        has = 1'b0;
        v   = 1'b0;
        if (empt)
        begin
            has = 1'b1;
            v   = allow_empty_r;
            clear_name();
            return;
        end
        n = pos_r + 11'd1;
        if (!fail_r)
        begin
            if (n >= limit_r)
                fail_r = 1'b1;
            scan_char(pos_r, c);
        end
        pos_r = (n < limit_r) ? n[LIMIT_W-1:0] : limit_r;
        if (fin)
        begin
            has = 1'b1;
            v   = !fail_r && n >= MIN_NAME_LEN && (!tag_hit_r || tail_r == UUID_LEN);
            clear_name();
        end
    endtask

    task automatic push_char(input logic [CH_W-1:0] c, input logic fin, input logic empt,
                             input int typed);
        logic has;
        logic v;
        while (!calm && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        s_axis_tuser  <= empt;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_name(c, fin, empt, has, v);
        if (has)
            verdict_q.insert(verdict_q.size(), (typed >= 0) ? typed[0] : v);
        items_sent++;
    endtask

    task automatic send_name(input logic fin, input int typed);
        int k;
        for (k = 0; k < name_buf.size(); k++)
            push_char(name_buf[k], fin && (k == name_buf.size() - 1), 1'b0,
                      (k == name_buf.size() - 1) ? typed : -1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[LIMIT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ALLOW_EMPTY)
            allow_empty_r = val[0];
        else
            limit_r = val[LIMIT_W-1:0];
    endtask

    function automatic logic [CH_W-1:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            name_buf.insert(name_buf.size(), s[k]);
    endtask

    task automatic add_digits(input int val, input int cnt);
        int div;
        div = 1;
        repeat (cnt - 1) div = div * 10;
        repeat (cnt)
        begin
            name_buf.insert(name_buf.size(), CH_W'(CH_0 + (val / div) % 10));
            div = div / 10;
        end
    endtask

    task automatic build_name();
        int roll;
        int k;
        string tag_text;
        tag_text = ":uuid:";
        name_buf.delete();
        add_text("nqn.");
        if ($urandom_range(99) < 4)
            name_buf[$urandom_range(3)] = pick(name_chars);
        add_digits(($urandom_range(99) < 80) ? $urandom_range(2010, 2099) : $urandom_range(9999), 4);
        name_buf.insert(name_buf.size(), CH_DASH);
        roll = $urandom_range(99);
        add_digits((roll < 85) ? $urandom_range(1, 12) : ((roll < 90) ? 0 : $urandom_range(13, 99)), 2);
        name_buf.insert(name_buf.size(), CH_DOT);
        repeat (($urandom_range(99) < 10) ? 0 : $urandom_range(1, 20))
            name_buf.insert(name_buf.size(), pick(name_chars));
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            add_text(tag_text);
            for (k = 0; k < 36; k++)
                name_buf.insert(name_buf.size(), (k == 8 || k == 13 || k == 18 || k == 23) ?
                                CH_DASH : pick(hex_chars));
            roll = $urandom_range(99);
            if (roll < 10)
                repeat ($urandom_range(1, 20)) void'(name_buf.pop_back());
            else if (roll < 20)
                repeat ($urandom_range(1, 4)) name_buf.insert(name_buf.size(), pick(name_chars));
            else if (roll < 30)
                name_buf[name_buf.size() - 1 - $urandom_range(35)] = pick(name_chars);
        end
        else if (roll < 60)
        begin
            add_text(tag_text.substr(0, $urandom_range(4)));
            repeat ($urandom_range(0, 6)) name_buf.insert(name_buf.size(), pick(name_chars));
        end
        if ($urandom_range(99) < 8)
            name_buf[$urandom_range(name_buf.size() - 1)] = CH_W'($urandom_range(255));
    endtask

    task automatic pick_settings();
        int lim;
        case ($urandom_range(7))
            0:       lim = 1;
            1:       lim = 12;
            2:       lim = 13;
            3:       lim = $urandom_range(14, 80);
            6:       lim = 1023;
            7:       lim = $urandom_range(1, 1023);
            default: lim = LIMIT_RESET;
        endcase
        write_reg(REG_ALLOW_EMPTY, $urandom_range(1));
        write_reg(REG_LENGTH_LIMIT, lim);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: verdict with none pending, expected none, got %0b",
                         $time, m_axis_tdata[0]);
                faults++;
            end
            else
            begin
                want_v = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want_v)
                begin
                    $display("%0t: valid_res expected %0b, got %0b",
                             $time, want_v, m_axis_tdata[0]);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("nvme_nqn_validator_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int r;
        int roll;
        int names_left;
        int rand_start;
        clear_name();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(dir_rows); r++)
        begin
            if (dir_rows[r].set_empty >= 0)
                write_reg(REG_ALLOW_EMPTY, dir_rows[r].set_empty);
            if (dir_rows[r].set_limit >= 0)
                write_reg(REG_LENGTH_LIMIT, dir_rows[r].set_limit);
            if (dir_rows[r].empt)
                push_char(8'hFF, 1'b1, 1'b1, dir_rows[r].verdict);
            else
            begin
                name_buf.delete();
                add_text(dir_rows[r].text);
                repeat (dir_rows[r].pad) name_buf.insert(name_buf.size(), CH_LA);
                if (dir_rows[r].poke_at >= 0)
                    name_buf[dir_rows[r].poke_at] = CH_W'(dir_rows[r].poke_val);
                send_name(dir_rows[r].fin, dir_rows[r].verdict);
            end
        end

        write_reg(REG_LENGTH_LIMIT, LIMIT_RESET);
        rand_start = items_sent;
        names_left = $urandom_range(20, 40);
        while (items_sent < rand_start + RAND_ITEMS)
        begin
            if (names_left == 0)
            begin
                pick_settings();
                names_left = $urandom_range(20, 40);
            end
            names_left--;
            calm = (items_sent >= rand_start + 40) && (items_sent < rand_start + 130);
            roll = $urandom_range(99);
            if (roll < 5)
                push_char(CH_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, -1);
            else if (roll < 12)
            begin
                name_buf.delete();
                repeat ($urandom_range(1, 16))
                    name_buf.insert(name_buf.size(), CH_W'($urandom_range(255)));
                send_name(1'b1, -1);
            end
            else if (roll < 17)
            begin
                // drop a partial name with an empty-name transaction
                build_name();
                send_name(1'b0, -1);
                push_char(CH_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, -1);
            end
            else
            begin
                build_name();
                send_name(1'b1, -1);
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (faults == 0)
            $display("nvme_nqn_validator_unit: match");
        else
            $display("nvme_nqn_validator_unit: mismatch");
        $finish;
    end

endmodule
